// ----- src/smom_pkg.sv -----
// ---------------------------------------------------------------------------
// smom_pkg
// Shared constants and state encoding for the square-root-of-minus-one core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package smom_pkg;

    localparam int PRIME_BITS       = 32;
    localparam int NONRESIDUE_TRIES = 512;
    localparam int FIRST_CANDIDATE  = 2;

    localparam int P_W   = 32;
    localparam int W_W   = 64;
    localparam int TRY_W = $clog2(NONRESIDUE_TRIES + 1);
    localparam int Z_W   = $clog2(NONRESIDUE_TRIES + FIRST_CANDIDATE + 1);
    localparam int E_W   = 6;

    typedef enum logic [29:0] {
        S_IDLE   = 30'd1 << 0,
        S_CHK    = 30'd1 << 1,
        S_QS     = 30'd1 << 2,
        S_ZTRY   = 30'd1 << 3,
        S_ZMOD_W = 30'd1 << 4,
        S_POW    = 30'd1 << 5,
        S_PMA_W  = 30'd1 << 6,
        S_PSQ_W  = 30'd1 << 7,
        S_EULER  = 30'd1 << 8,
        S_C      = 30'd1 << 9,
        S_T      = 30'd1 << 10,
        S_R      = 30'd1 << 11,
        S_TS     = 30'd1 << 12,
        S_V_W    = 30'd1 << 13,
        S_V_CHK  = 30'd1 << 14,
        S_B_CHK  = 30'd1 << 15,
        S_B_W    = 30'd1 << 16,
        S_R_W    = 30'd1 << 17,
        S_C_W    = 30'd1 << 18,
        S_T_W    = 30'd1 << 19,
        S_RCHK_W = 30'd1 << 20,
        S_P2_W   = 30'd1 << 21,
        S_RR_W   = 30'd1 << 22,
        S_DIV_W  = 30'd1 << 23,
        S_DIV2_W = 30'd1 << 24,
        S_INV_W  = 30'd1 << 25,
        S_CORR_W = 30'd1 << 26,
        S_CP_W   = 30'd1 << 27,
        S_LIFT   = 30'd1 << 28,
        S_FCHK_W = 30'd1 << 29
    } t_state;

endpackage

// ----- src/smom_modmul.sv -----
// ---------------------------------------------------------------------------
// smom_modmul
// Bit-serial modular multiplier: a*b mod m, one multiplier bit per double-then-add step pair.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module smom_modmul
    import smom_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_go,
    input  logic [W_W-1:0] i_a,
    input  logic [W_W-1:0] i_b,
    input  logic [W_W-1:0] i_m,
    input  logic           i_wide,
    output logic           o_done,
    output logic [W_W-1:0] o_prod
);

    logic [W_W-1:0] r_acc, n_acc;
    logic [W_W-1:0] r_a, n_a;
    logic [W_W-1:0] r_b, n_b;
    logic [W_W-1:0] r_m, n_m;
    logic [E_W-1:0] r_cnt, n_cnt;
    logic           r_ph, n_ph;
    logic           r_busy, n_busy;
    logic           r_done, n_done;
    logic [W_W:0]   w_sum;

    always_comb begin
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_m    = r_m;
        n_cnt  = r_cnt;
        n_ph   = r_ph;
        n_busy = r_busy;
        n_done = 1'b0;
        w_sum  = '0;
        if (i_go) begin
            n_acc  = '0;
            n_a    = i_a;
            n_b    = i_wide ? i_b : {i_b[P_W-1:0], {(W_W-P_W){1'b0}}};
            n_m    = i_m;
            n_cnt  = i_wide ? E_W'(W_W - 1) : E_W'(P_W - 1);
            n_ph   = 1'b0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!r_ph) begin
                w_sum = {r_acc, 1'b0};
                n_acc = (w_sum >= {1'b0, r_m}) ? W_W'(w_sum - {1'b0, r_m}) : W_W'(w_sum);
                n_ph  = 1'b1;
            end else begin
                w_sum = {1'b0, r_acc} + {1'b0, r_a};
                if (r_b[W_W-1]) begin
                    n_acc = (w_sum >= {1'b0, r_m}) ? W_W'(w_sum - {1'b0, r_m})
                                                   : W_W'(w_sum);
                end
                n_b  = {r_b[W_W-2:0], 1'b0};
                n_ph = 1'b0;
                if (r_cnt == '0) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_ph   <= n_ph;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_m   <= n_m;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ----- src/smom_divider.sv -----
// ---------------------------------------------------------------------------
// smom_divider
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module smom_divider
    import smom_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_go,
    input  logic [W_W-1:0] i_num,
    input  logic [P_W-1:0] i_den,
    output logic           o_done,
    output logic [W_W-1:0] o_quo,
    output logic [P_W-1:0] o_rem
);

    logic [P_W:0]   r_rem, n_rem;
    logic [W_W-1:0] r_num, n_num;
    logic [P_W-1:0] r_den, n_den;
    logic [E_W-1:0] r_cnt, n_cnt;
    logic           r_busy, n_busy;
    logic           r_done, n_done;
    logic [P_W:0]   w_trial;

    always_comb begin
        n_rem   = r_rem;
        n_num   = r_num;
        n_den   = r_den;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        w_trial = {r_rem[P_W-1:0], r_num[W_W-1]};
        if (i_go) begin
            n_rem  = '0;
            n_num  = i_num;
            n_den  = i_den;
            n_cnt  = E_W'(W_W - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = w_trial - {1'b0, r_den};
                n_num = {r_num[W_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_num = {r_num[W_W-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_num <= n_num;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_num;
    assign o_rem  = r_rem[P_W-1:0];

endmodule

// ----- src/sqrt_minus_one_mod_prime_square_core.sv -----
// ---------------------------------------------------------------------------
// sqrt_minus_one_mod_prime_square_core
// Square roots of minus one modulo p*p by Tonelli-Shanks and one Hensel step.
// ---------------------------------------------------------------------------
// Latency depends on p. Every multiply, including the final 64-bit check, runs
// on one shared bit-serial multiplier.
// One word is processed at a time; busy stays high until o_valid pulses.
// The receiver cannot stall: o_valid is high for one cycle; the result words hold until the next result.
// Synchronous active-low reset returns the sequencer to idle.
`timescale 1ns / 1ps

module sqrt_minus_one_mod_prime_square_core
    import smom_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  logic [31:0]    i_prime,
    output logic           o_valid,
    output logic [63:0]    o_root_lifted,
    output logic [63:0]    o_root_other,
    output logic           o_ok
);

    t_state r_state, n_state, r_ret, n_ret;

    logic [P_W-1:0]   r_p, n_p;
    logic [P_W-1:0]   r_q, n_q;
    logic [E_W-1:0]   r_s, n_s;
    logic [Z_W-1:0]   r_z, n_z;
    logic [TRY_W-1:0] r_tries, n_tries;
    logic [P_W-1:0]   r_zr, n_zr;
    logic [P_W-1:0]   r_pacc, n_pacc;
    logic [P_W-1:0]   r_pbase, n_pbase;
    logic [P_W-1:0]   r_pexp, n_pexp;
    logic [E_W-1:0]   r_m, n_m;
    logic [E_W-1:0]   r_i, n_i;
    logic [E_W-1:0]   r_k, n_k;
    logic [P_W-1:0]   r_c, n_c;
    logic [P_W-1:0]   r_t, n_t;
    logic [P_W-1:0]   r_r, n_r;
    logic [P_W-1:0]   r_v, n_v;
    logic [P_W-1:0]   r_b, n_b;
    logic [W_W-1:0]   r_p2, n_p2;
    logic [W_W-1:0]   r_w, n_w;
    logic [P_W-1:0]   r_qm, n_qm;
    logic [W_W-1:0]   r_lift, n_lift;

    logic             r_mgo, n_mgo;
    logic [W_W-1:0]   r_ma, n_ma, r_mb, n_mb, r_mm, n_mm;
    logic             r_mwide, n_mwide;
    logic             r_dgo, n_dgo;
    logic [W_W-1:0]   r_dnum, n_dnum;

    logic             r_valid, n_valid;
    logic             r_ok, n_ok;
    logic [W_W-1:0]   r_rl, n_rl, r_ro, n_ro;

    logic             w_mdone, w_ddone;
    logic [W_W-1:0]   w_prod, w_quo;
    logic [P_W-1:0]   w_rem;
    logic [P_W-1:0]   w_pm1;
    logic [P_W-1:0]   w_prod_p;
    logic [E_W:0]     w_kim;

    smom_modmul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_mgo),
        .i_a     (r_ma),
        .i_b     (r_mb),
        .i_m     (r_mm),
        .i_wide  (r_mwide),
        .o_done  (w_mdone),
        .o_prod  (w_prod)
    );

    smom_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_dgo),
        .i_num   (r_dnum),
        .i_den   (r_p),
        .o_done  (w_ddone),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    assign w_pm1    = r_p - 1'b1;
    assign w_prod_p = w_prod[P_W-1:0];
    assign w_kim    = {1'b0, r_k} + {1'b0, r_i} + 1'b1;

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_p     = r_p;
        n_q     = r_q;
        n_s     = r_s;
        n_z     = r_z;
        n_tries = r_tries;
        n_zr    = r_zr;
        n_pacc  = r_pacc;
        n_pbase = r_pbase;
        n_pexp  = r_pexp;
        n_m     = r_m;
        n_i     = r_i;
        n_k     = r_k;
        n_c     = r_c;
        n_t     = r_t;
        n_r     = r_r;
        n_v     = r_v;
        n_b     = r_b;
        n_p2    = r_p2;
        n_w     = r_w;
        n_qm    = r_qm;
        n_lift  = r_lift;
        n_mgo   = 1'b0;
        n_ma    = r_ma;
        n_mb    = r_mb;
        n_mm    = {{(W_W-P_W){1'b0}}, r_p};
        n_mwide = 1'b0;
        n_dgo   = 1'b0;
        n_dnum  = r_dnum;
        n_valid = 1'b0;
        n_ok    = r_ok;
        n_rl    = r_rl;
        n_ro    = r_ro;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_p     = P_W'(i_prime[PRIME_BITS-1:0]);
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_p < P_W'(5) || r_p[1:0] != 2'b01) begin
                    n_valid = 1'b1;
                    n_ok    = 1'b0;
                    n_rl    = '0;
                    n_ro    = '0;
                    n_state = S_IDLE;
                end else begin
                    n_q     = w_pm1;
                    n_s     = '0;
                    n_state = S_QS;
                end
            end
            S_QS: begin
                // Strip the factors of two from p-1, one per cycle.
                if (!r_q[0]) begin
                    n_q = {1'b0, r_q[P_W-1:1]};
                    n_s = r_s + 1'b1;
                end else begin
                    n_z     = Z_W'(FIRST_CANDIDATE);
                    n_tries = '0;
                    n_state = S_ZTRY;
                end
            end
            S_ZTRY: begin
                if (r_tries == TRY_W'(NONRESIDUE_TRIES)) begin
                    n_valid = 1'b1;
                    n_ok    = 1'b0;
                    n_rl    = '0;
                    n_ro    = '0;
                    n_state = S_IDLE;
                end else begin
                    n_dgo   = 1'b1;
                    n_dnum  = W_W'(r_z);
                    n_state = S_ZMOD_W;
                end
            end
            S_ZMOD_W: begin
                if (w_ddone) begin
                    n_zr    = w_rem;
                    n_pacc  = P_W'(1);
                    n_pbase = w_rem;
                    n_pexp  = {1'b0, w_pm1[P_W-1:1]};
                    n_ret   = S_EULER;
                    n_state = S_POW;
                end
            end
            S_POW: begin
                // Right-to-left square and multiply; returns to r_ret.
                if (r_pexp == '0) begin
                    n_state = r_ret;
                end else if (r_pexp[0]) begin
                    n_mgo   = 1'b1;
                    n_ma    = W_W'(r_pacc);
                    n_mb    = W_W'(r_pbase);
                    n_state = S_PMA_W;
                end else begin
                    n_mgo   = 1'b1;
                    n_ma    = W_W'(r_pbase);
                    n_mb    = W_W'(r_pbase);
                    n_state = S_PSQ_W;
                end
            end
            S_PMA_W: begin
                if (w_mdone) begin
                    n_pacc  = w_prod_p;
                    n_mgo   = 1'b1;
                    n_ma    = W_W'(r_pbase);
                    n_mb    = W_W'(r_pbase);
                    n_state = S_PSQ_W;
                end
            end
            S_PSQ_W: begin
                if (w_mdone) begin
                    n_pbase = w_prod_p;
                    n_pexp  = {1'b0, r_pexp[P_W-1:1]};
                    n_state = S_POW;
                end
            end
            S_EULER: begin
                if (r_pacc == w_pm1) begin
                    n_m     = r_s;
                    n_pacc  = P_W'(1);
                    n_pbase = r_zr;
                    n_pexp  = r_q;
                    n_ret   = S_C;
                    n_state = S_POW;
                end else begin
                    n_z     = r_z + 1'b1;
                    n_tries = r_tries + 1'b1;
                    n_state = S_ZTRY;
                end
            end
            S_C: begin
                n_c     = r_pacc;
                n_pacc  = P_W'(1);
                n_pbase = w_pm1;
                n_pexp  = r_q;
                n_ret   = S_T;
                n_state = S_POW;
            end
            S_T: begin
                n_t     = r_pacc;
                n_pacc  = P_W'(1);
                n_pbase = w_pm1;
                n_pexp  = P_W'(({1'b0, r_q} + 1'b1) >> 1);
                n_ret   = S_R;
                n_state = S_POW;
            end
            S_R: begin
                n_r     = r_pacc;
                n_state = S_TS;
            end
            S_TS: begin
                if (r_t == P_W'(1)) begin
                    n_mgo   = 1'b1;
                    n_ma    = W_W'(r_r);
                    n_mb    = W_W'(r_r);
                    n_state = S_RCHK_W;
                end else begin
                    n_i     = E_W'(1);
                    n_mgo   = 1'b1;
                    n_ma    = W_W'(r_t);
                    n_mb    = W_W'(r_t);
                    n_state = S_V_W;
                end
            end
            S_V_W: begin
                if (w_mdone) begin
                    n_v     = w_prod_p;
                    n_state = S_V_CHK;
                end
            end
            S_V_CHK: begin
                if (r_v != P_W'(1) && r_i < r_m) begin
                    n_i     = r_i + 1'b1;
                    n_mgo   = 1'b1;
                    n_ma    = W_W'(r_v);
                    n_mb    = W_W'(r_v);
                    n_state = S_V_W;
                end else if (r_i >= r_m) begin
                    n_valid = 1'b1;
                    n_ok    = 1'b0;
                    n_rl    = '0;
                    n_ro    = '0;
                    n_state = S_IDLE;
                end else begin
                    n_b     = r_c;
                    n_k     = '0;
                    n_state = S_B_CHK;
                end
            end
            S_B_CHK: begin
                if (w_kim < {1'b0, r_m}) begin
                    n_k     = r_k + 1'b1;
                    n_mgo   = 1'b1;
                    n_ma    = W_W'(r_b);
                    n_mb    = W_W'(r_b);
                    n_state = S_B_W;
                end else begin
                    n_mgo   = 1'b1;
                    n_ma    = W_W'(r_r);
                    n_mb    = W_W'(r_b);
                    n_state = S_R_W;
                end
            end
            S_B_W: begin
                if (w_mdone) begin
                    n_b     = w_prod_p;
                    n_state = S_B_CHK;
                end
            end
            S_R_W: begin
                if (w_mdone) begin
                    n_r     = w_prod_p;
                    n_mgo   = 1'b1;
                    n_ma    = W_W'(r_b);
                    n_mb    = W_W'(r_b);
                    n_state = S_C_W;
                end
            end
            S_C_W: begin
                if (w_mdone) begin
                    n_c     = w_prod_p;
                    n_mgo   = 1'b1;
                    n_ma    = W_W'(r_t);
                    n_mb    = w_prod;
                    n_state = S_T_W;
                end
            end
            S_T_W: begin
                if (w_mdone) begin
                    n_t     = w_prod_p;
                    n_m     = r_i;
                    n_state = S_TS;
                end
            end
            S_RCHK_W: begin
                if (w_mdone) begin
                    if (w_prod_p != w_pm1) begin
                        n_valid = 1'b1;
                        n_ok    = 1'b0;
                        n_rl    = '0;
                        n_ro    = '0;
                        n_state = S_IDLE;
                    end else begin
                        // p*p is below 2^64-1, so this modulus gives the plain product.
                        n_mgo   = 1'b1;
                        n_ma    = W_W'(r_p);
                        n_mb    = W_W'(r_p);
                        n_mm    = '1;
                        n_state = S_P2_W;
                    end
                end
            end
            S_P2_W: begin
                if (w_mdone) begin
                    n_p2    = w_prod;
                    n_mgo   = 1'b1;
                    n_ma    = W_W'(r_r);
                    n_mb    = W_W'(r_r);
                    n_mm    = w_prod;
                    n_state = S_RR_W;
                end
            end
            S_RR_W: begin
                if (w_mdone) begin
                    n_dgo   = 1'b1;
                    n_dnum  = w_prod + 1'b1;
                    n_state = S_DIV_W;
                end
            end
            S_DIV_W: begin
                if (w_ddone) begin
                    n_dgo   = 1'b1;
                    n_dnum  = w_quo;
                    n_state = S_DIV2_W;
                end
            end
            S_DIV2_W: begin
                if (w_ddone) begin
                    // Since r*r = -1, the inverse of 2r is (p-r)*(p+1)/2 mod p.
                    n_qm    = w_rem;
                    n_mgo   = 1'b1;
                    n_ma    = W_W'(r_p - r_r);
                    n_mb    = W_W'(({1'b0, r_p} + 1'b1) >> 1);
                    n_state = S_INV_W;
                end
            end
            S_INV_W: begin
                if (w_mdone) begin
                    n_mgo   = 1'b1;
                    n_ma    = W_W'(r_qm);
                    n_mb    = w_prod;
                    n_state = S_CORR_W;
                end
            end
            S_CORR_W: begin
                if (w_mdone) begin
                    n_mgo   = 1'b1;
                    n_ma    = w_prod;
                    n_mb    = W_W'(r_p);
                    n_mm    = '1;
                    n_state = S_CP_W;
                end
            end
            S_CP_W: begin
                if (w_mdone) begin
                    n_w     = w_prod;
                    n_state = S_LIFT;
                end
            end
            S_LIFT: begin
                if (W_W'(r_r) >= r_w) begin
                    n_lift = W_W'(r_r) - r_w;
                end else begin
                    n_lift = W_W'(r_r) + (r_p2 - r_w);
                end
                n_mgo   = 1'b1;
                n_ma    = n_lift;
                n_mb    = n_lift;
                n_mm    = r_p2;
                n_mwide = 1'b1;
                n_state = S_FCHK_W;
            end
            S_FCHK_W: begin
                if (w_mdone) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                    if (w_prod == r_p2 - 1'b1) begin
                        n_ok = 1'b1;
                        n_rl = r_lift;
                        n_ro = r_p2 - r_lift;
                    end else begin
                        n_ok = 1'b0;
                        n_rl = '0;
                        n_ro = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_mgo   <= 1'b0;
            r_dgo   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_mgo   <= n_mgo;
            r_dgo   <= n_dgo;
            r_valid <= n_valid;
        end
        r_p     <= n_p;
        r_q     <= n_q;
        r_s     <= n_s;
        r_z     <= n_z;
        r_tries <= n_tries;
        r_zr    <= n_zr;
        r_pacc  <= n_pacc;
        r_pbase <= n_pbase;
        r_pexp  <= n_pexp;
        r_m     <= n_m;
        r_i     <= n_i;
        r_k     <= n_k;
        r_c     <= n_c;
        r_t     <= n_t;
        r_r     <= n_r;
        r_v     <= n_v;
        r_b     <= n_b;
        r_p2    <= n_p2;
        r_w     <= n_w;
        r_qm    <= n_qm;
        r_lift  <= n_lift;
        r_ma    <= n_ma;
        r_mb    <= n_mb;
        r_mm    <= n_mm;
        r_mwide <= n_mwide;
        r_dnum  <= n_dnum;
        r_ok    <= n_ok;
        r_rl    <= n_rl;
        r_ro    <= n_ro;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_ok          = r_ok;
    assign o_root_lifted = r_rl;
    assign o_root_other  = r_ro;

endmodule
